FILE: rtl/fbcm_pkg.sv
// ----------------------------------------------------------------------------
// fbcm_pkg
// Shared types and constants of the block chain manager: command and result
// words, operation and status codes, link marks and header word indexes.
// ----------------------------------------------------------------------------
package fbcm_pkg;

    localparam int MAX_BLOCKS_DEF       = 4096;
    localparam int FIRST_DATA_BLOCK_DEF = 5;
    localparam int SECTOR_BYTES_DEF     = 8192;

    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RST = 13'd64;

    localparam logic [1:0] FUNC_FORMAT = 2'd0;
    localparam logic [1:0] FUNC_ALLOC  = 2'd1;
    localparam logic [1:0] FUNC_FREE   = 2'd2;
    localparam logic [1:0] FUNC_LOCATE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BROKEN  = 2'd2;
    localparam logic [1:0] ST_BADREQ  = 2'd3;

    localparam logic [15:0] LINK_END  = 16'hFFFF;
    localparam logic [15:0] LINK_FREE = 16'h0000;

    localparam logic [2:0] HDR_CSUM  = 3'd1;
    localparam logic [2:0] HDR_NCSUM = 3'd2;
    localparam logic [2:0] HDR_FREE  = 3'd3;
    localparam logic [2:0] HDR_FIRST = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [12:0] block_count;
        logic [11:0] start_block;
        logic [24:0] byte_offset;
        logic [25:0] span_bytes;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] result_block;
        logic [12:0] result_blocks;
        logic [11:0] free_blocks;
        logic [15:0] table_checksum;
        logic        unformatted;
    } t_res;

endpackage

FILE: rtl/fbcm_link_ram.sv
// ----------------------------------------------------------------------------
// fbcm_link_ram
// Link table store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbcm_link_ram #(
    parameter int MAX_BLOCKS = fbcm_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(MAX_BLOCKS)-1:0] i_waddr,
    input  logic [15:0]                   i_wdata,
    input  logic [$clog2(MAX_BLOCKS)-1:0] i_raddr,
    output logic [15:0]                   o_rdata
);

    logic [15:0] r_mem [MAX_BLOCKS];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fbcm_seq.sv
// ----------------------------------------------------------------------------
// fbcm_seq
// Operation sequencer: sweeps, scans and chain walks over the link table,
// then the checksum and free-count sweep, header update after a table write and result word.
// ----------------------------------------------------------------------------
module fbcm_seq #(
    parameter int MAX_BLOCKS       = fbcm_pkg::MAX_BLOCKS_DEF,
    parameter int FIRST_DATA_BLOCK = fbcm_pkg::FIRST_DATA_BLOCK_DEF,
    parameter int SECTOR_BYTES     = fbcm_pkg::SECTOR_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  fbcm_pkg::t_cmd                i_cmd,
    input  logic [fbcm_pkg::CFG_W-1:0]    i_total_blocks,
    output logic                          o_done,
    output fbcm_pkg::t_res                o_res,
    output logic                          o_we,
    output logic [$clog2(MAX_BLOCKS)-1:0] o_waddr,
    output logic [15:0]                   o_wdata,
    output logic [$clog2(MAX_BLOCKS)-1:0] o_raddr,
    input  logic [15:0]                   i_rdata
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int PW = AW + 1;
    localparam int SB = $clog2(SECTOR_BYTES);
    localparam int NW = 28;
    localparam int KW = 29;
    localparam logic [PW-1:0] P_FIRST = PW'(FIRST_DATA_BLOCK);
    localparam logic [PW-1:0] P_LAST  = PW'(MAX_BLOCKS - 1);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_CLEAR    = 13'b0000000000010,
        S_SCAN     = 13'b0000000000100,
        S_LINK     = 13'b0000000001000,
        S_LINK_END = 13'b0000000010000,
        S_FR_RD    = 13'b0000000100000,
        S_FR_CHK   = 13'b0000001000000,
        S_LC_RD    = 13'b0000010000000,
        S_LC_CHK   = 13'b0000100000000,
        S_SUM      = 13'b0001000000000,
        S_HDR      = 13'b0010000000000,
        S_FLAG_RD  = 13'b0100000000000,
        S_FLAG     = 13'b1000000000000
    } t_state;

    t_state         r_state, n_state;
    logic [PW-1:0]  r_ptr, n_ptr;
    logic           r_pv, n_pv;
    logic [AW-1:0]  r_pa, n_pa;
    logic [15:0]    r_fill, n_fill;
    logic           r_fmt, n_fmt;
    logic           r_hdr, n_hdr;
    logic [2:0]     r_hidx, n_hidx;
    logic [12:0]    r_want, n_want;
    logic [12:0]    r_got, n_got;
    logic           r_first, n_first;
    logic [AW-1:0]  r_prev, n_prev;
    logic [AW-1:0]  r_blk, n_blk;
    logic [AW-1:0]  r_here, n_here;
    logic [KW-1:0]  r_cnt, n_cnt;
    logic [KW-1:0]  r_hops, n_hops;
    logic [KW-1:0]  r_steps, n_steps;
    logic [NW-1:0]  r_need, n_need;
    logic [1:0]     r_status, n_status;
    logic [11:0]    r_rblock, n_rblock;
    logic [12:0]    r_rblocks, n_rblocks;
    logic [15:0]    r_xor, n_xor;
    logic [12:0]    r_free, n_free;
    logic           r_done, n_done;
    fbcm_pkg::t_res r_res, n_res;

    logic [12:0]    t_eff;
    logic [13:0]    scan_end;
    logic           stop;
    logic           issue;
    logic [NW-1:0]  need_c;
    logic [KW-1:0]  hops_c;

    function automatic logic f_in_data(input logic [15:0] x, input logic [12:0] t);
        return (x >= 16'(FIRST_DATA_BLOCK)) && (x < {3'b000, t});
    endfunction

    assign t_eff = (i_total_blocks > 13'(MAX_BLOCKS)) ? 13'(MAX_BLOCKS) : i_total_blocks;

    // byte offset split into whole sectors and the remainder; sector size is a power of two
    assign hops_c = KW'(i_cmd.byte_offset >> SB);
    assign need_c = NW'((NW'(i_cmd.byte_offset[SB-1:0]) + NW'(i_cmd.span_bytes)
                       + NW'(SECTOR_BYTES - 1)) >> SB);

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_pv      = 1'b0;
        n_pa      = r_pa;
        n_fill    = r_fill;
        n_fmt     = r_fmt;
        n_hdr     = r_hdr;
        n_hidx    = r_hidx;
        n_want    = r_want;
        n_got     = r_got;
        n_first   = r_first;
        n_prev    = r_prev;
        n_blk     = r_blk;
        n_here    = r_here;
        n_cnt     = r_cnt;
        n_hops    = r_hops;
        n_steps   = r_steps;
        n_need    = r_need;
        n_status  = r_status;
        n_rblock  = r_rblock;
        n_rblocks = r_rblocks;
        n_xor     = r_xor;
        n_free    = r_free;
        n_done    = 1'b0;
        n_res     = r_res;
        o_we      = 1'b0;
        o_waddr   = r_ptr[AW-1:0];
        o_wdata   = r_fill;
        o_raddr   = r_ptr[AW-1:0];

        // streaming read front end shared by the scans and the sum sweep
        scan_end = (r_state == S_SUM) ? 14'(MAX_BLOCKS) : {1'b0, t_eff};
        stop     = ((r_state == S_SCAN) || (r_state == S_LINK)) && (r_got == r_want);
        issue    = (14'(r_ptr) < scan_end) && !stop;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_status  = fbcm_pkg::ST_OK;
                    n_rblock  = 12'd0;
                    n_rblocks = 13'd0;
                    n_cnt     = '0;
                    n_fmt     = 1'b0;
                    n_hdr     = 1'b0;
                    n_ptr     = P_FIRST;
                    n_xor     = 16'h0000;
                    n_free    = 13'd0;
                    case (i_cmd.func)
                        fbcm_pkg::FUNC_FORMAT: begin
                            n_fmt   = 1'b1;
                            n_fill  = fbcm_pkg::LINK_FREE;
                            n_ptr   = '0;
                            n_state = S_CLEAR;
                        end
                        fbcm_pkg::FUNC_ALLOC: begin
                            n_want  = (i_cmd.block_count == 13'd0) ? 13'd1 : i_cmd.block_count;
                            n_got   = 13'd0;
                            n_state = S_SCAN;
                        end
                        fbcm_pkg::FUNC_FREE: begin
                            n_rblock = i_cmd.start_block;
                            n_blk    = AW'(i_cmd.start_block);
                            if (!f_in_data({4'b0000, i_cmd.start_block}, t_eff)) begin
                                n_status = fbcm_pkg::ST_BROKEN;
                                n_state  = S_SUM;
                            end else begin
                                n_state = S_FR_RD;
                            end
                        end
                        default: begin
                            n_blk   = AW'(i_cmd.start_block);
                            n_hops  = hops_c;
                            n_need  = need_c;
                            n_steps = hops_c + KW'(need_c) - KW'(1);
                            if (i_cmd.span_bytes == 26'd0) begin
                                n_status = fbcm_pkg::ST_BADREQ;
                                n_state  = S_SUM;
                            end else if (!f_in_data({4'b0000, i_cmd.start_block}, t_eff)) begin
                                n_status = fbcm_pkg::ST_BROKEN;
                                n_state  = S_SUM;
                            end else begin
                                n_state = S_LC_RD;
                            end
                        end
                    endcase
                end
            end

            S_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_ptr[AW-1:0];
                o_wdata = r_fill;
                if (r_ptr == P_LAST) begin
                    if (r_fmt) begin
                        n_hdr   = 1'b1;
                        n_ptr   = P_FIRST;
                        n_xor   = 16'h0000;
                        n_free  = 13'd0;
                        n_state = S_SUM;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_ptr = r_ptr + PW'(1);
                end
            end

            S_SCAN: begin
                if (issue) begin
                    n_pv  = 1'b1;
                    n_pa  = r_ptr[AW-1:0];
                    n_ptr = r_ptr + PW'(1);
                end
                if (r_pv && (r_got < r_want) && (i_rdata == fbcm_pkg::LINK_FREE)) begin
                    n_got = r_got + 13'd1;
                end
                if (stop || (!issue && !r_pv)) begin
                    n_pv  = 1'b0;
                    n_ptr = P_FIRST;
                    if (r_got < r_want) begin
                        n_status = fbcm_pkg::ST_NOSPACE;
                        n_xor    = 16'h0000;
                        n_free   = 13'd0;
                        n_state  = S_SUM;
                    end else begin
                        n_got   = 13'd0;
                        n_first = 1'b1;
                        n_state = S_LINK;
                    end
                end
            end

            S_LINK: begin
                if (issue) begin
                    n_pv  = 1'b1;
                    n_pa  = r_ptr[AW-1:0];
                    n_ptr = r_ptr + PW'(1);
                end
                if (r_pv && (r_got < r_want) && (i_rdata == fbcm_pkg::LINK_FREE)) begin
                    if (r_first) begin
                        n_rblock = 12'(r_pa);
                        n_first  = 1'b0;
                    end else begin
                        // link the previous free block to this one
                        o_we    = 1'b1;
                        o_waddr = r_prev;
                        o_wdata = 16'(r_pa);
                    end
                    n_prev = r_pa;
                    n_got  = r_got + 13'd1;
                end
                if (stop || (!issue && !r_pv)) begin
                    n_pv    = 1'b0;
                    n_state = S_LINK_END;
                end
            end

            S_LINK_END: begin
                o_we      = 1'b1;
                o_waddr   = r_prev;
                o_wdata   = fbcm_pkg::LINK_END;
                n_rblocks = r_want;
                n_hdr     = 1'b1;
                n_ptr     = P_FIRST;
                n_xor     = 16'h0000;
                n_free    = 13'd0;
                n_state   = S_SUM;
            end

            S_FR_RD: begin
                o_raddr = r_blk;
                n_state = S_FR_CHK;
            end

            S_FR_CHK: begin
                o_we      = 1'b1;
                o_waddr   = r_blk;
                o_wdata   = fbcm_pkg::LINK_FREE;
                n_rblocks = r_rblocks + 13'd1;
                if (i_rdata == fbcm_pkg::LINK_END) begin
                    n_hdr   = 1'b1;
                    n_state = S_SUM;
                end else if ((i_rdata == fbcm_pkg::LINK_FREE) || !f_in_data(i_rdata, t_eff)) begin
                    n_status = fbcm_pkg::ST_BROKEN;
                    n_hdr    = 1'b1;
                    n_state  = S_SUM;
                end else begin
                    n_blk   = i_rdata[AW-1:0];
                    n_state = S_FR_RD;
                end
            end

            S_LC_RD: begin
                if (r_cnt == r_hops) begin
                    n_here = r_blk;
                end
                if (r_cnt == r_steps) begin
                    n_rblock  = 12'((r_cnt == r_hops) ? r_blk : r_here);
                    n_rblocks = (r_need > NW'(13'h1FFF)) ? 13'h1FFF : r_need[12:0];
                    n_state   = S_SUM;
                end else begin
                    o_raddr = r_blk;
                    n_state = S_LC_CHK;
                end
            end

            S_LC_CHK: begin
                if ((i_rdata == fbcm_pkg::LINK_END) || (i_rdata == fbcm_pkg::LINK_FREE)
                    || !f_in_data(i_rdata, t_eff)) begin
                    n_status  = fbcm_pkg::ST_BROKEN;
                    n_rblock  = 12'd0;
                    n_rblocks = 13'd0;
                    n_state   = S_SUM;
                end else begin
                    n_blk   = i_rdata[AW-1:0];
                    n_cnt   = r_cnt + KW'(1);
                    n_state = S_LC_RD;
                end
            end

            S_SUM: begin
                if (issue) begin
                    n_pv  = 1'b1;
                    n_pa  = r_ptr[AW-1:0];
                    n_ptr = r_ptr + PW'(1);
                end
                if (r_pv) begin
                    n_xor = r_xor ^ i_rdata;
                    if ((i_rdata == fbcm_pkg::LINK_FREE) && (13'(r_pa) < t_eff)) begin
                        n_free = r_free + 13'd1;
                    end
                end
                if (!issue && !r_pv) begin
                    n_hidx  = fbcm_pkg::HDR_CSUM;
                    n_state = r_hdr ? S_HDR : S_FLAG_RD;
                end
            end

            S_HDR: begin
                o_waddr = AW'(r_hidx);
                case (r_hidx)
                    fbcm_pkg::HDR_CSUM:  o_wdata = r_xor;
                    fbcm_pkg::HDR_NCSUM: o_wdata = ~r_xor;
                    fbcm_pkg::HDR_FREE:  o_wdata = 16'(r_free);
                    default:             o_wdata = 16'(FIRST_DATA_BLOCK);
                endcase
                o_we = (5'(r_hidx) < 5'(FIRST_DATA_BLOCK))
                       && ((r_hidx != fbcm_pkg::HDR_FIRST) || r_fmt);
                if (r_hidx == fbcm_pkg::HDR_FIRST) begin
                    n_state = S_FLAG_RD;
                end else begin
                    n_hidx = r_hidx + 3'd1;
                end
            end

            S_FLAG_RD: begin
                o_raddr = '0;
                n_state = S_FLAG;
            end

            S_FLAG: begin
                n_res.status         = r_status;
                n_res.result_block   = r_rblock;
                n_res.result_blocks  = r_rblocks;
                n_res.free_blocks    = r_free[11:0];
                n_res.table_checksum = r_xor;
                n_res.unformatted    = (i_rdata == fbcm_pkg::LINK_END);
                n_done               = 1'b1;
                n_state              = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // blank medium: sweep the whole table to the end mark
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_pv    <= 1'b0;
            r_fill  <= fbcm_pkg::LINK_END;
            r_fmt   <= 1'b0;
            r_hdr   <= 1'b0;
            r_done  <= 1'b0;
            r_xor   <= 16'hFFFF;
            r_free  <= 13'd0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_pv    <= n_pv;
            r_fill  <= n_fill;
            r_fmt   <= n_fmt;
            r_hdr   <= n_hdr;
            r_done  <= n_done;
            r_xor   <= n_xor;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa      <= n_pa;
        r_hidx    <= n_hidx;
        r_want    <= n_want;
        r_got     <= n_got;
        r_first   <= n_first;
        r_prev    <= n_prev;
        r_blk     <= n_blk;
        r_here    <= n_here;
        r_cnt     <= n_cnt;
        r_hops    <= n_hops;
        r_steps   <= n_steps;
        r_need    <= n_need;
        r_status  <= n_status;
        r_rblock  <= n_rblock;
        r_rblocks <= n_rblocks;
        r_res     <= n_res;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: rtl/fat_block_chain_manager_core.sv
// ----------------------------------------------------------------------------
// fat_block_chain_manager_core
// Block allocation table manager: format, allocate, free chain and locate
// over a table of 16-bit next-block links held in one synchronous memory.
// ----------------------------------------------------------------------------
// A new command is taken only while busy is low, one operation at a time.
// Every operation ends with a sweep of every data entry through the single link
//   memory read port to refresh checksum and free count.
// Reset: synchronous; a clearing pass writes the end mark to every entry while
//   busy is high. The receiver cannot stall results.
module fat_block_chain_manager_core #(
    parameter int MAX_BLOCKS       = fbcm_pkg::MAX_BLOCKS_DEF,
    parameter int FIRST_DATA_BLOCK = fbcm_pkg::FIRST_DATA_BLOCK_DEF,
    parameter int SECTOR_BYTES     = fbcm_pkg::SECTOR_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  fbcm_pkg::t_cmd             i_cmd,
    output logic                       o_done,
    output fbcm_pkg::t_res             o_res,
    input  logic                       i_cfg_we,
    input  logic [fbcm_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_BLOCKS);

    // medium size register; clamped to the table depth inside the sequencer
    logic [fbcm_pkg::CFG_W-1:0] r_total_blocks;

    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic [AW-1:0] raddr;
    logic [15:0]   rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_blocks <= fbcm_pkg::TOTAL_BLOCKS_RST;
        end else if (i_cfg_we) begin
            r_total_blocks <= i_cfg_data;
        end
    end

    // sequencer: owns the operation flow and the result word
    fbcm_seq #(
        .MAX_BLOCKS       (MAX_BLOCKS),
        .FIRST_DATA_BLOCK (FIRST_DATA_BLOCK),
        .SECTOR_BYTES     (SECTOR_BYTES)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_cmd          (i_cmd),
        .i_total_blocks (r_total_blocks),
        .o_done         (o_done),
        .o_res          (o_res),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_raddr        (raddr),
        .i_rdata        (rdata)
    );

    // link table: one write and one registered read per cycle
    fbcm_link_ram #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule
